// ===== rtl/mbt_pkg.sv =====
package mbt_pkg;

  localparam int C_W    = 32;
  localparam int WIN_W  = 8;
  localparam int STEP_W = 9;
  localparam int IDX_W  = 8;

  localparam logic [IDX_W-1:0] CFG_FAST_WINDOW = 8'd0;
  localparam logic [IDX_W-1:0] CFG_SLOW_WINDOW = 8'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd100;

  typedef struct packed {
    logic load;
    logic upd;
    logic finish;
  } mbt_cmd_t;

  typedef struct packed {
    logic escaped;
    logic last;
  } mbt_status_t;

endpackage

// ===== rtl/mbt_datapath.sv =====
module mbt_datapath
  import mbt_pkg::*;
#(
  parameter int FRAC_BITS = 29
) (
  input  logic                    clk,
  input  logic signed [C_W-1:0]   in_c_re,
  input  logic signed [C_W-1:0]   in_c_im,
  input  logic [WIN_W-1:0]        fast_window,
  input  logic [WIN_W-1:0]        slow_window,
  input  mbt_cmd_t                cmd,
  output mbt_status_t             status,
  output logic                    out_on_boundary,
  output logic [STEP_W-1:0]       out_escape_step
);

  localparam int ZW  = ((FRAC_BITS > 29) ? FRAC_BITS : 29) + 7;
  localparam int MW  = ZW - 1;
  localparam int HW  = (MW + 1) / 2;
  localparam int PPW = 2 * HW;
  localparam int PW  = 2 * MW;
  localparam logic [PW:0] ESC_LIM = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  logic [C_W-1:0]    c_re_r;
  logic [C_W-1:0]    c_im_r;
  logic [MW-1:0]     zr_mag_r;
  logic [MW-1:0]     zi_mag_r;
  logic              zr_neg_r;
  logic              zi_neg_r;
  logic [STEP_W-1:0] step_r;
  logic [PPW-1:0]    pp_r   [3][4];
  logic [PPW-1:0]    pp_nxt [3][4];
  logic [PW-1:0]     prod_r [3];
  logic [PW-1:0]     prod_nxt [3];
  logic [MW-1:0]     opa [3];
  logic [MW-1:0]     opb [3];
  logic              on_boundary_r;
  logic [STEP_W-1:0] escape_step_r;

  logic [PW:0]       sq_sum;
  logic [ZW-1:0]     sr;
  logic [ZW-1:0]     si;
  logic [ZW-1:0]     xm;
  logic [ZW-1:0]     xs;
  logic [ZW-1:0]     zr_new;
  logic [ZW-1:0]     zi_new;
  logic [ZW-1:0]     zr_abs;
  logic [ZW-1:0]     zi_abs;
  logic [STEP_W-1:0] total;

  assign opa[0] = zr_mag_r;
  assign opb[0] = zr_mag_r;
  assign opa[1] = zi_mag_r;
  assign opb[1] = zi_mag_r;
  assign opa[2] = zr_mag_r;
  assign opb[2] = zi_mag_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pp_nxt[k][0] = PPW'(opa[k][HW-1:0]) * PPW'(opb[k][HW-1:0]);
      pp_nxt[k][1] = PPW'(opa[k][HW-1:0]) * PPW'(opb[k][MW-1:HW]);
      pp_nxt[k][2] = PPW'(opa[k][MW-1:HW]) * PPW'(opb[k][HW-1:0]);
      pp_nxt[k][3] = PPW'(opa[k][MW-1:HW]) * PPW'(opb[k][MW-1:HW]);
      prod_nxt[k] = PW'(pp_r[k][0]) + (PW'(pp_r[k][1]) << HW)
                  + (PW'(pp_r[k][2]) << HW) + (PW'(pp_r[k][3]) << (2 * HW));
    end
  end

  always_ff @(posedge clk) begin
    pp_r   <= pp_nxt;
    prod_r <= prod_nxt;
  end

  always_comb begin
    sq_sum = {1'b0, prod_r[0]} + {1'b0, prod_r[1]};
    sr     = ZW'(prod_r[0] >> FRAC_BITS);
    si     = ZW'(prod_r[1] >> FRAC_BITS);
    xm     = ZW'(prod_r[2] >> (FRAC_BITS - 1));
    xs     = (zr_neg_r ^ zi_neg_r) ? (~xm + ZW'(1)) : xm;
    zr_new = sr - si + {{(ZW-C_W){c_re_r[C_W-1]}}, c_re_r};
    zi_new = xs + {{(ZW-C_W){c_im_r[C_W-1]}}, c_im_r};
    zr_abs = zr_new[ZW-1] ? (~zr_new + ZW'(1)) : zr_new;
    zi_abs = zi_new[ZW-1] ? (~zi_new + ZW'(1)) : zi_new;
    total  = {1'b0, fast_window} + {1'b0, slow_window};
  end

  assign status.escaped = (sq_sum > ESC_LIM);
  assign status.last    = (step_r == total);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re_r   <= in_c_re;
      c_im_r   <= in_c_im;
      zr_mag_r <= '0;
      zi_mag_r <= '0;
      zr_neg_r <= 1'b0;
      zi_neg_r <= 1'b0;
      step_r   <= '0;
    end else if (cmd.upd) begin
      zr_mag_r <= zr_abs[MW-1:0];
      zi_mag_r <= zi_abs[MW-1:0];
      zr_neg_r <= zr_new[ZW-1];
      zi_neg_r <= zi_new[ZW-1];
      step_r   <= step_r + STEP_W'(1);
    end
    if (cmd.finish) begin
      on_boundary_r <= status.escaped && (step_r > {1'b0, fast_window});
      escape_step_r <= status.escaped ? step_r : '0;
    end
  end

  assign out_on_boundary = on_boundary_r;
  assign out_escape_step = escape_step_r;

endmodule

// ===== rtl/mbt_ctrl.sv =====
module mbt_ctrl
  import mbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mbt_status_t status,
  output mbt_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_UPD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   done;
  logic   out_free;

  assign done     = status.escaped || status.last;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (done) begin
          if (out_free) begin
            cmd.finish    = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.upd   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/mandelbrot_boundary_test_top.sv =====
// Tests one complex point c (signed fixed point, FRAC_BITS fractional bits) per item by
// iterating z = z*z + c from zero and reports the step at which |z| first exceeds 2 and
// whether that step falls in the second window. Each iteration passes through the
// split partial-product multipliers, the product adders, then the escape compare and z
// update. An item that escapes at step E, or runs to the end with E = fast_window +
// slow_window, raises out_valid when its last step is done, held back while an earlier
// result waits; the next item can be accepted at the following edge while that result
// waits at the output, but no new item is accepted while one is still iterating.
// Window registers take effect for the next item and should be written while idle.
module mandelbrot_boundary_test_top
  import mbt_pkg::*;
#(
  parameter int FRAC_BITS = 29
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [C_W-1:0] in_c_re,
  input  logic signed [C_W-1:0] in_c_im,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_on_boundary,
  output logic [STEP_W-1:0]     out_escape_step,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [WIN_W-1:0]      cfg_data
);

  logic [WIN_W-1:0] fast_window_r;
  logic [WIN_W-1:0] slow_window_r;
  mbt_cmd_t         cmd;
  mbt_status_t      status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_window_r <= WINDOW_RESET;
      slow_window_r <= WINDOW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FAST_WINDOW: fast_window_r <= cfg_data;
        CFG_SLOW_WINDOW: slow_window_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mbt_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .in_c_re         (in_c_re),
    .in_c_im         (in_c_im),
    .fast_window     (fast_window_r),
    .slow_window     (slow_window_r),
    .cmd             (cmd),
    .status          (status),
    .out_on_boundary (out_on_boundary),
    .out_escape_step (out_escape_step)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mbt_pkg::*;

  localparam int FRAC = 29;
  localparam int ONE = 1 << FRAC;
  localparam logic signed [127:0] ESC_LIMIT = 128'sd1 <<< (2 * FRAC + 2);

  typedef struct {
    logic                boundary;
    logic [STEP_W-1:0]   step;
  } verdict_t;

  class escape_tracker;
    logic [WIN_W-1:0] fast_win;
    logic [WIN_W-1:0] slow_win;
    verdict_t         due[$];
    int               errors;
    int               points;
    int               boundary_hits;
    int               never_escaped;

    function new();
      fast_win = WINDOW_RESET;
      slow_win = WINDOW_RESET;
    endfunction

    function void set_window(logic [IDX_W-1:0] idx, logic [WIN_W-1:0] val);
      if (idx == CFG_FAST_WINDOW) begin
        fast_win = val;
      end else if (idx == CFG_SLOW_WINDOW) begin
        slow_win = val;
      end
    endfunction

    // Exact product shifted right, rounded toward zero.
    function logic signed [63:0] scaled_product(logic signed [63:0] a, logic signed [63:0] b,
                                                int sh);
      logic signed [127:0] p;
      logic [127:0]        m;
      p = a * b;
      m = p[127] ? -p : p;
      m = m >> sh;
      return p[127] ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    function verdict_t escape_time(logic signed [C_W-1:0] c_re, logic signed [C_W-1:0] c_im);
      logic signed [63:0]  zr;
      logic signed [63:0]  zi;
      logic signed [63:0]  sr;
      logic signed [63:0]  si;
      logic signed [63:0]  x;
      logic signed [127:0] mag2;
      int                  total;
      int                  hit;
      verdict_t            v;
      zr = 0;
      zi = 0;
      hit = 0;
      total = int'(fast_win) + int'(slow_win);
      for (int n = 1; n <= total && hit == 0; n++) begin
        sr = scaled_product(zr, zr, FRAC);
        si = scaled_product(zi, zi, FRAC);
        x = scaled_product(zr, zi, FRAC - 1);
        zr = sr - si + c_re;
        zi = x + c_im;
        mag2 = zr * zr + zi * zi;
        if (mag2 > ESC_LIMIT) begin
          hit = n;
        end
      end
      v.boundary = (hit != 0) && (hit > int'(fast_win));
      v.step = hit[STEP_W-1:0];
      return v;
    endfunction

    function void note_point(logic signed [C_W-1:0] c_re, logic signed [C_W-1:0] c_im);
      due.push_back(escape_time(c_re, c_im));
      points++;
    endfunction

    function void check_result(logic boundary, logic [STEP_W-1:0] step);
      verdict_t v;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual on_boundary %0b escape_step %0d",
                 $time, boundary, step);
        return;
      end
      v = due.pop_front();
      if (step !== v.step) begin
        errors++;
        $display("%0t: escape_step expected %0d, actual %0d", $time, v.step, step);
      end
      if (boundary !== v.boundary) begin
        errors++;
        $display("%0t: on_boundary expected %0b, actual %0b", $time, v.boundary, boundary);
      end
      if (v.boundary) begin
        boundary_hits++;
      end
      if (v.step == 0) begin
        never_escaped++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [C_W-1:0] in_c_re;
  logic signed [C_W-1:0] in_c_im;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_on_boundary;
  logic [STEP_W-1:0]     out_escape_step;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index;
  logic [WIN_W-1:0]      cfg_data;

  bit                    idle_en;
  int                    settings;
  escape_tracker         sb = new();

  mandelbrot_boundary_test_top #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_c_re        (in_c_re),
    .in_c_im        (in_c_im),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_on_boundary(out_on_boundary),
    .out_escape_step(out_escape_step),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_on_boundary, out_escape_step);
    end
  end

  task automatic send_point(input logic signed [C_W-1:0] re, input logic signed [C_W-1:0] im);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_c_re <= re;
    in_c_im <= im;
    do @(posedge clk); while (!in_ready);
    sb.note_point(re, im);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_window(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly points in and around the set, where escape times spread out.
  task automatic pick_point(output logic signed [C_W-1:0] re, output logic signed [C_W-1:0] im);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      re = $urandom;
      im = $urandom;
    end else if (sel < 7) begin
      re = int'($urandom_range(0, 1449551462)) - 1127428915;
      im = int'($urandom_range(0, 1395864371)) - 697932185;
    end else if (sel == 7) begin
      re = ONE / 4 + int'($urandom_range(0, 1 << 22));
      im = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    end else if (sel == 8) begin
      re = -3 * (ONE / 4) + int'($urandom_range(0, 1 << 21)) - (1 << 20);
      im = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    end else begin
      re = int'($urandom_range(0, 5 * (ONE / 2) * 2)) - 5 * (ONE / 2);
      im = int'($urandom_range(0, 1 << 24)) - (1 << 23);
    end
  endtask

  initial begin
    logic signed [C_W-1:0] re;
    logic signed [C_W-1:0] im;
    logic [WIN_W-1:0]      fw;
    logic [WIN_W-1:0]      sw;
    int                    n_items;

    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_c_re = '0;
    in_c_im = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_en = 1'b1;
    settings = 1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_point(0, 0);
    send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_point(32'sh80000000, 32'sh80000000);
    send_point(32'sh7FFFFFFF, 0);
    send_point(0, 32'sh80000000);
    send_point(-1, -1);
    send_point(-2 * ONE, 0);
    send_point(2 * ONE, 0);
    send_point(0, ONE);
    send_point(0, 2 * ONE);
    send_point(ONE / 4 + ONE / 100, 0);
    send_point(ONE / 4 + ONE / 400, 0);
    send_point(ONE / 4 + ONE / 2000, 0);
    send_point(-3 * (ONE / 4), ONE / 100);
    send_point(-3 * (ONE / 4), ONE / 1000);

    hold_until_drained();
    write_window(CFG_FAST_WINDOW, '0);
    settings++;
    send_point(ONE / 4 + ONE / 100, 0);
    send_point(2 * ONE, 0);
    send_point(0, 0);

    hold_until_drained();
    write_window(CFG_FAST_WINDOW, WINDOW_RESET);
    write_window(CFG_SLOW_WINDOW, '0);
    write_window(IDX_W'(CFG_SLOW_WINDOW + 1), 8'd7);
    write_window({IDX_W{1'b1}}, 8'd3);
    settings++;
    send_point(-3 * (ONE / 4), ONE / 100);
    send_point(2 * ONE, 0);
    send_point(0, 0);

    for (int ph = 0; ph < 12; ph++) begin
      n_items = 110;
      case (ph)
        0: begin
          fw = 8'd1;
          sw = 8'd1;
          n_items = 30;
        end
        1: begin
          fw = 8'd255;
          sw = 8'd255;
          n_items = 30;
        end
        2: begin
          fw = 8'd255;
          sw = 8'd1;
          n_items = 30;
        end
        3: begin
          fw = 8'd1;
          sw = 8'd255;
          n_items = 30;
        end
        4: begin
          fw = '0;
          sw = WIN_W'($urandom_range(1, 40));
        end
        5: begin
          fw = WIN_W'($urandom_range(1, 40));
          sw = '0;
        end
        default: begin
          fw = WIN_W'($urandom_range(1, 40));
          sw = WIN_W'($urandom_range(1, 40));
        end
      endcase
      hold_until_drained();
      write_window(CFG_FAST_WINDOW, fw);
      write_window(CFG_SLOW_WINDOW, sw);
      if ($urandom_range(0, 1) == 1) begin
        write_window(IDX_W'($urandom_range(CFG_SLOW_WINDOW + 1, {IDX_W{1'b1}})),
                     WIN_W'($urandom));
      end
      settings++;
      idle_en = (ph < 10) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) == 0) begin
          hold_until_drained();
        end
        pick_point(re, im);
        send_point(re, im);
      end
    end

    hold_until_drained();
    repeat (1600) @(posedge clk);
    $display("Tested %0d points under %0d window settings.", sb.points, settings);
    $display("%0d were boundary points and %0d never escaped.",
             sb.boundary_hits, sb.never_escaped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mbt_pkg.sv
rtl/mbt_datapath.sv
rtl/mbt_ctrl.sv
rtl/mandelbrot_boundary_test_top.sv
sim/tb_top.sv
